// File: sv/format_stream_integer_printer_assert.svh
`ifndef FORMAT_STREAM_INTEGER_PRINTER_ASSERT_SVH
`define FORMAT_STREAM_INTEGER_PRINTER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define FSIP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fsip assertion failed");

// next-cycle implication, checked outside reset
`define FSIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fsip assertion failed");

`endif

// File: sv/fsip_pkg.sv
package fsip_pkg;

	// argument width used by conversions
	localparam int ARG_BITS   = 64;
	localparam int HEX_DIGITS = (ARG_BITS + 3) / 4;
	localparam int ARG_PAD    = HEX_DIGITS * 4;
	// floor(ARG_BITS * log10(2)) + 1
	localparam int DEC_DIGITS = (ARG_BITS * 30103) / 100000 + 1;
	localparam int DIG_W      = DEC_DIGITS * 4;
	localparam int REM_W      = $clog2(DEC_DIGITS + 1);
	localparam int CNT_W      = $clog2(HEX_DIGITS + 1);

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_HEX     = 8'h78;
	localparam logic [7:0] CH_DEC     = 8'h64;

	typedef struct packed {
		logic busy;
		logic done;
	} b2d_stat_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		return (d < 4'd10) ? ({4'h0, d} + 8'd48) : ({4'h0, d} + 8'd55);
	endfunction

	// one double-dabble step: correct every digit, then shift in one bit
	function automatic logic [DIG_W-1:0] dabble_step(input logic [DIG_W-1:0] bcd,
			input logic b);
		logic [DIG_W-1:0] corr;
		corr = bcd;
		for (int i = 0; i < DEC_DIGITS; i++) begin
			if (bcd[i*4 +: 4] >= 4'd5) begin
				corr[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
			end
		end
		return {corr[DIG_W-2:0], b};
	endfunction

endpackage

// File: sv/fsip_b2d.sv
// binary to bcd, four argument bits per cycle
module fsip_b2d (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [fsip_pkg::ARG_PAD-1:0]    value,
	output fsip_pkg::b2d_stat_t             stat,
	output logic [fsip_pkg::DIG_W-1:0]      bcd
);

	logic                          busy_q;
	logic                          done_q;
	logic [fsip_pkg::CNT_W-1:0]    cnt_q;
	logic [fsip_pkg::ARG_PAD-1:0]  sh_q;
	logic [fsip_pkg::DIG_W-1:0]    bcd_q;
	logic [fsip_pkg::DIG_W-1:0]    step_v;

	always_comb begin
		step_v = bcd_q;
		for (int k = 0; k < 4; k++) begin
			step_v = fsip_pkg::dabble_step(step_v, sh_q[fsip_pkg::ARG_PAD-1-k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == fsip_pkg::CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= value;
			bcd_q <= '0;
			cnt_q <= fsip_pkg::CNT_W'(fsip_pkg::HEX_DIGITS);
		end else if (busy_q) begin
			sh_q  <= sh_q << 4;
			bcd_q <= step_v;
			cnt_q <= cnt_q - fsip_pkg::CNT_W'(1);
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign bcd       = bcd_q;

endmodule

// File: sv/format_stream_integer_printer.sv
// channel | direction | fields                | handshake
// in      | request   | format_char, arg_value | in_valid / in_stall
// out     | result    | out_char, last_char    | out_valid / out_stall
//
// one item at a time; in_stall is high until the last result enters the output register
// literal: accepted into S_LIT, then pushed into the output register once it has room
// hex: accepted into S_EMIT, then 16 nibbles, most significant first, leading zeros dropped
// decimal: the argument goes through the bcd converter (4 bits a cycle), then 20 digits are shifted out
// all control state clears on arst_n; out_stall holds digit pushes, leading zeros still shift

`include "format_stream_integer_printer_assert.svh"

module format_stream_integer_printer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  format_char,
	input  logic [63:0] arg_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_char,
	output logic        last_char
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CONV = 4'b0010,
		S_EMIT = 4'b0100,
		S_LIT  = 4'b1000
	} state_t;

	state_t                          state_q;
	logic                            pend_q;      // '%' seen, conversion pending
	logic                            out_valid_q;
	logic [7:0]                      out_char_q;
	logic                            last_q;
	logic [7:0]                      lit_q;
	logic [fsip_pkg::DIG_W-1:0]      dig_q;       // digits, most significant on top
	logic [fsip_pkg::REM_W-1:0]      rem_q;       // digits still in dig_q
	logic                            seen_q;      // a digit was already emitted

	logic                            accept;
	logic                            slot_free;
	logic                            skip;
	logic                            push_dig;
	logic                            push_lit;
	logic                            conv_start;
	logic [3:0]                      top_dig;
	logic [fsip_pkg::ARG_PAD-1:0]    arg_pad;
	fsip_pkg::b2d_stat_t             conv_stat;
	logic [fsip_pkg::DIG_W-1:0]      conv_bcd;

	assign in_stall   = (state_q != S_IDLE);
	assign accept     = in_valid && !in_stall;
	// output register can take a new result this cycle
	assign slot_free  = !out_valid_q || !out_stall;
	assign top_dig    = dig_q[fsip_pkg::DIG_W-1 -: 4];
	// leading zero, but never drop the final digit
	assign skip       = !seen_q && (top_dig == 4'd0) && (rem_q != fsip_pkg::REM_W'(1));
	assign push_dig   = (state_q == S_EMIT) && !skip && slot_free;
	assign push_lit   = (state_q == S_LIT) && slot_free;
	assign conv_start = accept && pend_q && (format_char == fsip_pkg::CH_DEC);
	assign arg_pad    = fsip_pkg::ARG_PAD'(arg_value[fsip_pkg::ARG_BITS-1:0]);

	fsip_b2d u_b2d (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (conv_start),
		.value  (arg_pad),
		.stat   (conv_stat),
		.bcd    (conv_bcd)
	);

	// control: state, pending flag, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (push_dig || push_lit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (pend_q) begin
							if (format_char != fsip_pkg::CH_PERCENT) begin
								pend_q <= 1'b0;
								if (format_char == fsip_pkg::CH_HEX) begin
									state_q <= S_EMIT;
								end else if (format_char == fsip_pkg::CH_DEC) begin
									state_q <= S_CONV;
								end else begin
									state_q <= S_LIT;
								end
							end
						end else if (format_char == fsip_pkg::CH_PERCENT) begin
							pend_q <= 1'b1;
						end else begin
							state_q <= S_LIT;
						end
					end
				end
				S_CONV: begin
					if (conv_stat.done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (push_dig && rem_q == fsip_pkg::REM_W'(1)) begin
						state_q <= S_IDLE;
					end
				end
				S_LIT: begin
					if (push_lit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath: digit shift register and output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			lit_q  <= format_char;
			// hex digits sit top-aligned, straight from the argument
			dig_q  <= fsip_pkg::DIG_W'(arg_pad) << (fsip_pkg::DIG_W - fsip_pkg::ARG_PAD);
			rem_q  <= fsip_pkg::REM_W'(fsip_pkg::HEX_DIGITS);
			seen_q <= 1'b0;
		end else if (state_q == S_CONV && conv_stat.done) begin
			dig_q  <= conv_bcd;
			rem_q  <= fsip_pkg::REM_W'(fsip_pkg::DEC_DIGITS);
			seen_q <= 1'b0;
		end else if (state_q == S_EMIT && (skip || push_dig)) begin
			dig_q <= dig_q << 4;
			rem_q <= rem_q - fsip_pkg::REM_W'(1);
			if (push_dig) begin
				seen_q <= 1'b1;
			end
		end
		if (push_dig) begin
			out_char_q <= fsip_pkg::digit_char(top_dig);
			last_q     <= (rem_q == fsip_pkg::REM_W'(1));
		end else if (push_lit) begin
			out_char_q <= lit_q;
			last_q     <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign last_char = last_q;

	`FSIP_ASSERT_NOW(a_pend_idle_only, clk, arst_n, state_q != S_IDLE, !pend_q)
	`FSIP_ASSERT_NOW(a_done_in_conv, clk, arst_n, conv_stat.done, state_q == S_CONV)
	`FSIP_ASSERT_NOW(a_conv_quiet_idle, clk, arst_n, state_q == S_IDLE, !conv_stat.busy)
	`FSIP_ASSERT_NOW(a_emit_has_digits, clk, arst_n, state_q == S_EMIT,
		rem_q != fsip_pkg::REM_W'(0))
	`FSIP_ASSERT_NEXT(a_last_back_idle, clk, arst_n, push_dig && rem_q == fsip_pkg::REM_W'(1),
		state_q == S_IDLE && out_valid && last_char)

endmodule
